@@ sv/stack_sequence_checker_defines.svh @@
// Assertion macros for the stack sequence checker port assertions in ssc_checker.
`ifndef STACK_SEQUENCE_CHECKER_DEFINES_SVH
`define STACK_SEQUENCE_CHECKER_DEFINES_SVH

// Check a consequence in the same cycle as its antecedent.
`define SSC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check a consequence in the cycle after its antecedent.
`define SSC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/ssc_pkg.sv @@
// Shared types and constants for the stack sequence checker.
`timescale 1ns / 1ps
package ssc_pkg;

   localparam int CAR_W       = 7;
   localparam int CAR_MAX     = 127;
   localparam int NEXT_W      = CAR_W + 1;
   localparam int VERDICT_W   = 2;
   localparam int MAX_CARS_DEF = 64;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [VERDICT_W-1:0] VERDICT_RUNNING = 2'd0;
   localparam logic [VERDICT_W-1:0] VERDICT_ACCEPT  = 2'd1;
   localparam logic [VERDICT_W-1:0] VERDICT_REJECT  = 2'd2;

   typedef struct packed {
      logic [CAR_W-1:0] target_car;
      logic             first_item;
   } req_type;

   typedef struct packed {
      logic [VERDICT_W-1:0] verdict;
      logic                 sequence_done;
   } rsp_type;

   // Classified item handed from the front to the back.
   typedef struct packed {
      logic [CAR_W-1:0] target_car;
      logic             start;
      logic             done;
      logic             bad;
   } work_type;

endpackage

@@ sv/ssc_fifo.sv @@
// Small register FIFO used between the parts of the stack sequence checker.
`timescale 1ns / 1ps
module ssc_fifo #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entries_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign rdata   = entries_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   // Advance pointers with wrap, track fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store payload on transfer
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

@@ sv/ssc_front.sv @@
// Front part: holds the length register, counts items and classifies targets.
`timescale 1ns / 1ps
module ssc_front #(
   parameter int MAX_CARS = ssc_pkg::MAX_CARS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write,
   input  logic [ssc_pkg::CAR_W-1:0] csr_data,
   input  logic                     req_push,
   input  ssc_pkg::req_type         req_data,
   input  logic                     work_full,
   output logic                     work_push,
   output ssc_pkg::work_type        work_data
);
   import ssc_pkg::*;

   localparam logic [CAR_W-1:0] LEN_CAP =
      (MAX_CARS > CAR_MAX) ? CAR_W'(CAR_MAX) : CAR_W'(MAX_CARS);

   logic [CAR_W-1:0] seq_length_ff;
   logic [CAR_W-1:0] items_ff, items_in;
   logic             start_ff, start_in;
   logic [CAR_W-1:0] active_len;
   logic [CAR_W-1:0] item_cnt;
   logic             start, done, bad, accept;

   // Clamp the length into 1..MAX_CARS (at most CAR_MAX)
   assign active_len = (seq_length_ff == '0) ? CAR_W'(1) :
                       (seq_length_ff > LEN_CAP) ? LEN_CAP : seq_length_ff;

   // Classify the incoming item
   assign start    = req_data.first_item || start_ff;
   assign item_cnt = (start ? '0 : items_ff) + 1'b1;
   assign done     = (item_cnt >= active_len);
   assign bad      = (req_data.target_car == '0) || (req_data.target_car > active_len);
   assign accept   = req_push && !work_full;

   assign work_push            = req_push;
   assign work_data.target_car = req_data.target_car;
   assign work_data.start      = start;
   assign work_data.done       = done;
   assign work_data.bad        = bad;

   always_comb begin
      items_in = items_ff;
      start_in = start_ff;
      if (accept) begin
         items_in = done ? '0 : item_cnt;
         start_in = done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_length_ff <= CAR_W'(1);
         items_ff      <= '0;
         start_ff      <= 1'b1;
      end else begin
         if (csr_write) begin
            seq_length_ff <= csr_data;
         end
         items_ff <= items_in;
         start_ff <= start_in;
      end
   end

endmodule

@@ sv/ssc_back.sv @@
// Back part: runs the siding stack for each classified item and forms the verdict.
`timescale 1ns / 1ps
module ssc_back #(
   parameter int MAX_CARS = ssc_pkg::MAX_CARS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              work_empty,
   input  ssc_pkg::work_type work_data,
   output logic              work_pop,
   input  logic              rsp_full,
   output logic              rsp_push,
   output ssc_pkg::rsp_type  rsp_wdata
);
   import ssc_pkg::*;

   localparam int AW = (MAX_CARS > 1) ? $clog2(MAX_CARS) : 1;
   localparam int CW = $clog2(MAX_CARS + 1);

   typedef enum logic [1:0] {
      ST_FETCH,
      ST_PUSH,
      ST_REFILL
   } state_type;

   state_type         state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [NEXT_W-1:0] next_ff, next_in;
   logic              rej_ff, rej_in;
   logic [CAR_W-1:0]  top_ff, top_in;
   logic [CAR_W-1:0]  target_ff, target_in;

   logic [CAR_W-1:0]  siding_mem [MAX_CARS];
   logic [CAR_W-1:0]  rd_data_ff;
   logic              mem_we, mem_re;
   logic [AW-1:0]     mem_raddr;

   logic [CW-1:0]     eff_count;
   logic [NEXT_W-1:0] eff_next;
   logic              eff_rej;
   logic [NEXT_W-1:0] tgt_wide;

   // Apply a sequence start before handling the item
   assign eff_count = work_data.start ? '0 : count_ff;
   assign eff_next  = work_data.start ? NEXT_W'(1) : next_ff;
   assign eff_rej   = work_data.start ? 1'b0 : rej_ff;
   assign tgt_wide  = {1'b0, work_data.target_car};
   assign mem_raddr = AW'(eff_count - CW'(2));

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      next_in   = next_ff;
      rej_in    = rej_ff;
      top_in    = top_ff;
      target_in = target_ff;
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      work_pop  = 1'b0;
      rsp_push  = 1'b0;
      unique case (state_ff)
         // Take one item, decide pop, park or reject, and post its result
         ST_FETCH: begin
            if (!work_empty && !rsp_full) begin
               work_pop = 1'b1;
               rsp_push = 1'b1;
               count_in = eff_count;
               next_in  = eff_next;
               rej_in   = eff_rej;
               if (!eff_rej) begin
                  if (work_data.bad) begin
                     rej_in = 1'b1;
                  end else if (eff_count != '0 && top_ff == work_data.target_car) begin
                     count_in = eff_count - 1'b1;
                     if (eff_count > CW'(1)) begin
                        mem_re   = 1'b1;
                        state_in = ST_REFILL;
                     end
                  end else if (tgt_wide >= eff_next) begin
                     if (eff_next < tgt_wide && eff_count < CW'(MAX_CARS)) begin
                        target_in = work_data.target_car;
                        state_in  = ST_PUSH;
                     end else begin
                        next_in = tgt_wide + 1'b1;
                     end
                  end else begin
                     rej_in = 1'b1;
                  end
               end
            end
         end
         // Park one car per cycle until the target is reached or the siding is full
         ST_PUSH: begin
            mem_we   = 1'b1;
            top_in   = next_ff[CAR_W-1:0];
            count_in = count_ff + 1'b1;
            next_in  = next_ff + 1'b1;
            if ((next_ff + 1'b1) >= {1'b0, target_ff} ||
                (count_ff + 1'b1) >= CW'(MAX_CARS)) begin
               next_in  = {1'b0, target_ff} + 1'b1;
               state_in = ST_FETCH;
            end
         end
         // Load the new top of the siding after a pop
         ST_REFILL: begin
            top_in   = rd_data_ff;
            state_in = ST_FETCH;
         end
         default: begin
            state_in = ST_FETCH;
         end
      endcase
   end

   always_comb begin
      rsp_wdata.sequence_done = work_data.done;
      if (rej_in) begin
         rsp_wdata.verdict = VERDICT_REJECT;
      end else if (work_data.done) begin
         rsp_wdata.verdict = VERDICT_ACCEPT;
      end else begin
         rsp_wdata.verdict = VERDICT_RUNNING;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_FETCH;
         count_ff <= '0;
         next_ff  <= NEXT_W'(1);
         rej_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         next_ff  <= next_in;
         rej_ff   <= rej_in;
      end
      top_ff    <= top_in;
      target_ff <= target_in;
   end

   // Siding storage: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         siding_mem[count_ff[AW-1:0]] <= next_ff[CAR_W-1:0];
      end
      if (mem_re) begin
         rd_data_ff <= siding_mem[mem_raddr];
      end
   end

endmodule

@@ sv/stack_sequence_checker.sv @@
// Top level of the stack sequence checker: front, work queue, back, result queue.
//
//   channel  | ports                      | transfer when
//   ---------+----------------------------+-----------------------
//   request  | req_push req_full req_data | req_push && !req_full
//   response | rsp_pop rsp_empty rsp_data | rsp_pop && !rsp_empty
//   config   | csr_write csr_data         | csr_write
//
// The back decides each item in ST_FETCH, then parks each car below the target
// on the siding in ST_PUSH (up to MAX_CARS - 1 cars), or after a pop that leaves
// cars reads the new top in ST_REFILL, before it takes the next item.
// Two-entry queues sit between front and back and ahead of the response
// ports, so a stalled consumer blocks the back only once its queue is full.
// Reset is synchronous; it empties both queues and clears sequence state.
`timescale 1ns / 1ps
module stack_sequence_checker #(
   parameter int MAX_CARS = ssc_pkg::MAX_CARS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   output logic                      req_full,
   input  ssc_pkg::req_type          req_data,
   output logic                      rsp_empty,
   input  logic                      rsp_pop,
   output ssc_pkg::rsp_type          rsp_data,
   input  logic                      csr_write,
   input  logic [ssc_pkg::CAR_W-1:0] csr_data
);
   import ssc_pkg::*;

   logic     work_push, work_full, work_pop, work_empty;
   work_type work_wdata, work_rdata;
   logic     rsp_push, rsp_full;
   rsp_type  rsp_wdata;

   assign req_full = work_full;

   ssc_front #(.MAX_CARS(MAX_CARS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_data  (csr_data),
      .req_push  (req_push),
      .req_data  (req_data),
      .work_full (work_full),
      .work_push (work_push),
      .work_data (work_wdata)
   );

   ssc_fifo #(.WIDTH($bits(work_type)), .DEPTH(QUEUE_DEPTH)) u_work_q (
      .clock (clock),
      .reset (reset),
      .push  (work_push),
      .wdata (work_wdata),
      .full  (work_full),
      .pop   (work_pop),
      .rdata (work_rdata),
      .empty (work_empty)
   );

   ssc_back #(.MAX_CARS(MAX_CARS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .work_empty (work_empty),
      .work_data  (work_rdata),
      .work_pop   (work_pop),
      .rsp_full   (rsp_full),
      .rsp_push   (rsp_push),
      .rsp_wdata  (rsp_wdata)
   );

   ssc_fifo #(.WIDTH($bits(rsp_type)), .DEPTH(QUEUE_DEPTH)) u_rsp_q (
      .clock (clock),
      .reset (reset),
      .push  (rsp_push),
      .wdata (rsp_wdata),
      .full  (rsp_full),
      .pop   (rsp_pop),
      .rdata (rsp_data),
      .empty (rsp_empty)
   );

endmodule

@@ sv/ssc_checker.sv @@
// Port-level assertions for the stack sequence checker and their bind.
`timescale 1ns / 1ps
`include "stack_sequence_checker_defines.svh"
module ssc_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_full,
   input logic             rsp_empty,
   input logic             rsp_pop,
   input ssc_pkg::rsp_type rsp_data
);
   import ssc_pkg::*;

   logic rsp_valid;
   logic rsp_wait;
   logic rsp_accept;
   logic code_known;

   // Decode the result port state
   assign rsp_valid  = !rsp_empty;
   assign rsp_wait   = rsp_valid && !rsp_pop;
   assign rsp_accept = rsp_valid && (rsp_data.verdict == VERDICT_ACCEPT);
   assign code_known = (rsp_data.verdict == VERDICT_RUNNING) ||
                       (rsp_data.verdict == VERDICT_ACCEPT) ||
                       (rsp_data.verdict == VERDICT_REJECT);

   // Verdict code is always a defined one
   `SSC_ASSERT_NOW(a_verdict_code, clock, reset, rsp_valid, code_known, "undefined verdict code")

   // Accept only appears on the last item of a sequence
   `SSC_ASSERT_NOW(a_accept_on_done, clock, reset, rsp_accept, rsp_data.sequence_done, "early accept")

   // A waiting result holds until its transfer
   `SSC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_wait, rsp_valid && $stable(rsp_data), "result changed")

   // Reset leaves both sides empty and ready
   `SSC_ASSERT_NEXT(a_reset_clear, clock, 1'b0, reset, rsp_empty && !req_full, "queues not cleared")

endmodule

bind stack_sequence_checker ssc_checker u_ssc_checker (.*);

@@ tb/sv/tb_stack_sequence_checker.sv @@
// Self-checking testbench for the stack sequence checker: directed and random car orders.
`timescale 1ns / 1ps
module tb_stack_sequence_checker;
   import ssc_pkg::*;

   localparam int MAX_CARS       = MAX_CARS_DEF;
   localparam int RANDOM_ITEMS   = 1400;
   localparam int CALM_ITEMS     = 200;
   localparam int HOLD_CYCLES    = 300;
   localparam int SETTLE_CYCLES  = 80;
   localparam int WATCHDOG_LIMIT = 4000;

   typedef enum int {SEQ_VALID, SEQ_BROKEN, SEQ_NOISE} seq_kind_type;
   typedef enum int {FLAW_VALUE, FLAW_SWAP, FLAW_RESTART} flaw_kind_type;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_push  = 1'b0;
   logic                 req_full;
   req_type              req_data  = '0;
   logic                 rsp_empty;
   logic                 rsp_pop   = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_write = 1'b0;
   logic [CAR_W-1:0]     csr_data  = '0;

   // Stimulus and scoreboard storage
   req_type              pending_items[$];
   rsp_type              expected_verdicts[$];
   int unsigned          random_queued = 0;
   int unsigned          error_count   = 0;
   bit                   idle_enable   = 1'b1;
   bit                   hold_request  = 1'b0;

   // Shadow copy of the checker state
   logic [CAR_W-1:0]     shadow_siding [MAX_CARS];
   int unsigned          shadow_depth;
   int unsigned          shadow_next_car;
   int unsigned          shadow_seen;
   bit                   shadow_rejected;
   logic [CAR_W-1:0]     shadow_length;

   stack_sequence_checker #(.MAX_CARS(MAX_CARS)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_data  (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Clear the shadow sequence state
   function automatic void clear_shadow_sequence();
      shadow_depth    = 0;
      shadow_next_car = 1;
      shadow_seen     = 0;
      shadow_rejected = 1'b0;
   endfunction

   // Advance the shadow state by one target car and return its verdict
   function automatic rsp_type judge_target(req_type item);
      int unsigned target;
      int unsigned length;
      bit          done;
      rsp_type     verdict;
      target = 32'(item.target_car);
      if (item.first_item) clear_shadow_sequence();
      length = 32'(shadow_length);
      if (length == 0) length = 1;
      if (length > MAX_CARS) length = MAX_CARS;
      if (!shadow_rejected) begin
         if (target < 1 || target > length) begin
            shadow_rejected = 1'b1;
         end else if (shadow_depth > 0 && shadow_siding[shadow_depth-1] == target) begin
            shadow_depth--;
         end else if (target >= shadow_next_car) begin
            // park every unused car below the target
            while (shadow_next_car < target && shadow_depth < MAX_CARS) begin
               shadow_siding[shadow_depth] = shadow_next_car[CAR_W-1:0];
               shadow_depth++;
               shadow_next_car++;
            end
            shadow_next_car = target + 1;
         end else begin
            shadow_rejected = 1'b1;
         end
      end
      shadow_seen++;
      done = (shadow_seen >= length);
      if (shadow_rejected)
         verdict.verdict = VERDICT_REJECT;
      else if (done)
         verdict.verdict = VERDICT_ACCEPT;
      else
         verdict.verdict = VERDICT_RUNNING;
      verdict.sequence_done = done;
      if (done) clear_shadow_sequence();
      return verdict;
   endfunction

   // Driver: offer pending items, with random gaps
   int unsigned send_gap = 0;
   always @(posedge clock) begin
      bit accepted;
      bit offer;
      accepted = 1'b0;
      offer    = 1'b0;
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full) begin
            expected_verdicts.push_back(judge_target(req_data));
            void'(pending_items.pop_front());
            accepted = 1'b1;
         end
         if (send_gap > 0) begin
            send_gap--;
         end else if (pending_items.size() > 0 && (!req_push || accepted) && idle_enable &&
                      $urandom_range(0, 9) == 0) begin
            send_gap = $urandom_range(0, 7);
         end else begin
            offer = (pending_items.size() > 0);
         end
         req_push <= offer;
         if (offer) req_data <= pending_items[0];
      end
   end

   // Monitor: pop results, with random stalls and one long hold
   int unsigned rx_stall = 0;
   always @(posedge clock) begin
      rsp_type want;
      bit      pop;
      pop = 1'b0;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_verdicts.size() == 0) begin
               $display("%0t: result with nothing expected: verdict %0d done %0d",
                        $time, rsp_data.verdict, rsp_data.sequence_done);
               error_count++;
            end else begin
               want = expected_verdicts.pop_front();
               if (rsp_data.verdict !== want.verdict) begin
                  $display("%0t: verdict mismatch: expected %0d actual %0d",
                           $time, want.verdict, rsp_data.verdict);
                  error_count++;
               end
               if (rsp_data.sequence_done !== want.sequence_done) begin
                  $display("%0t: sequence_done mismatch: expected %0d actual %0d",
                           $time, want.sequence_done, rsp_data.sequence_done);
                  error_count++;
               end
            end
         end
         if (hold_request) begin
            rx_stall     = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (rx_stall > 0) begin
            rx_stall--;
         end else if (idle_enable && $urandom_range(0, 9) == 0) begin
            rx_stall = $urandom_range(0, 7);
         end else begin
            pop = 1'b1;
         end
         rsp_pop <= pop;
      end
   end

   // Watchdog: end the run when no transfer happens for too long
   int unsigned quiet_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty) || csr_write) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_stack_sequence_checker failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic enqueue_item(input int unsigned target, input bit first);
      req_type item;
      item.target_car = target[CAR_W-1:0];
      item.first_item = first;
      pending_items.push_back(item);
   endtask

   // Wait until every item is sent and every result is back, then settle
   task automatic wait_drained();
      while (pending_items.size() != 0 || expected_verdicts.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_length(input int unsigned value);
      @(posedge clock);
      csr_write     <= 1'b1;
      csr_data      <= value[CAR_W-1:0];
      shadow_length = value[CAR_W-1:0];
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   // Build one car order of the given kind and queue it
   task automatic enqueue_sequence(input int unsigned length, input seq_kind_type kind);
      logic [CAR_W-1:0] park [MAX_CARS];
      logic [CAR_W-1:0] order [MAX_CARS];
      logic [CAR_W-1:0] swap_car;
      int unsigned      next_car;
      int unsigned      depth;
      int unsigned      emitted;
      int unsigned      count;
      int unsigned      flaw_pos;
      int unsigned      other_pos;
      flaw_kind_type    flaw;
      bit               first;
      next_car = 1;
      depth    = 0;
      emitted  = 0;
      count    = length;
      flaw     = FLAW_VALUE;
      flaw_pos = 0;
      // walk a random push/pop schedule to get a feasible order
      while (emitted < length) begin
         if (depth > 0 && (next_car > length || $urandom_range(0, 1) == 1)) begin
            depth--;
            order[emitted] = park[depth];
            emitted++;
         end else begin
            park[depth] = next_car[CAR_W-1:0];
            depth++;
            next_car++;
         end
      end
      if (kind == SEQ_BROKEN) begin
         flaw_pos = $urandom_range(0, length - 1);
         flaw     = flaw_kind_type'($urandom_range(0, 2));
         if (flaw == FLAW_VALUE) begin
            order[flaw_pos] = CAR_W'($urandom_range(0, CAR_MAX));
         end else if (flaw == FLAW_SWAP) begin
            other_pos         = $urandom_range(0, length - 1);
            swap_car          = order[flaw_pos];
            order[flaw_pos]   = order[other_pos];
            order[other_pos]  = swap_car;
         end
      end else if (kind == SEQ_NOISE) begin
         count = $urandom_range(1, length);
         for (int i = 0; i < count; i++)
            order[i] = CAR_W'(($urandom_range(0, 1) == 1) ? $urandom_range(0, CAR_MAX)
                                                          : $urandom_range(1, length));
      end
      for (int i = 0; i < count; i++) begin
         if (i == 0)
            first = ($urandom_range(0, 99) < 85);
         else if (kind == SEQ_BROKEN && flaw == FLAW_RESTART && i == flaw_pos)
            first = 1'b1;
         else if (kind == SEQ_NOISE)
            first = ($urandom_range(0, 15) == 0);
         else
            first = 1'b0;
         enqueue_item(32'(order[i]), first);
         random_queued++;
      end
   endtask

   initial begin
      int unsigned  length_value;
      int unsigned  active;
      int unsigned  pick;
      int unsigned  seq_total;
      bit           first_random;
      seq_kind_type kind;

      shadow_length = 7'd1;
      clear_shadow_sequence();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset length of one: accept, target zero, target far above range
      enqueue_item(1, 1'b1);
      enqueue_item(0, 1'b0);
      enqueue_item(CAR_MAX, 1'b1);
      wait_drained();

      // Length zero counts as one
      write_length(0);
      enqueue_item(1, 1'b0);
      enqueue_item(2, 1'b1);
      wait_drained();

      // Three cars: infeasible order with an item after reject, straight, reversed
      write_length(3);
      enqueue_item(3, 1'b1);
      enqueue_item(1, 1'b0);
      enqueue_item(2, 1'b0);
      enqueue_item(1, 1'b1);
      enqueue_item(2, 1'b0);
      enqueue_item(3, 1'b0);
      enqueue_item(3, 1'b0);
      enqueue_item(2, 1'b0);
      enqueue_item(1, 1'b0);
      wait_drained();

      // Shorten the length in the middle of a running sequence
      write_length(5);
      enqueue_item(2, 1'b1);
      enqueue_item(1, 1'b0);
      wait_drained();
      write_length(3);
      enqueue_item(3, 1'b0);
      wait_drained();

      // Length above the car limit clamps; deep park, restart, pop, out of range
      write_length(CAR_MAX);
      enqueue_item(MAX_CARS, 1'b1);
      enqueue_item(MAX_CARS, 1'b1);
      enqueue_item(MAX_CARS - 1, 1'b0);
      enqueue_item(MAX_CARS + 1, 1'b1);
      wait_drained();

      // Random phases: a length setting, then a batch of sequences
      first_random = 1'b1;
      while (random_queued < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (first_random)   length_value = 4;
         else if (pick < 55) length_value = $urandom_range(1, 8);
         else if (pick < 75) length_value = $urandom_range(9, 20);
         else if (pick < 85) length_value = $urandom_range(21, MAX_CARS - 1);
         else if (pick < 90) length_value = 0;
         else                length_value = $urandom_range(MAX_CARS, CAR_MAX);
         active = (length_value == 0) ? 1 : (length_value > MAX_CARS) ? MAX_CARS : length_value;
         seq_total = first_random ? 12 : $urandom_range(1, (active >= 32) ? 2 : 48 / active + 1);
         if (random_queued + CALM_ITEMS >= RANDOM_ITEMS) idle_enable = 1'b0;
         write_length(length_value);
         // hold the receiver so the block fills and pushes back
         if (first_random) hold_request = 1'b1;
         for (int s = 0; s < seq_total; s++) begin
            pick = $urandom_range(0, 99);
            kind = (pick < 70) ? SEQ_VALID : (pick < 85) ? SEQ_BROKEN : SEQ_NOISE;
            enqueue_sequence(active, kind);
         end
         first_random = 1'b0;
         wait_drained();
      end

      if (error_count == 0)
         $display("tb_stack_sequence_checker passed");
      else
         $display("tb_stack_sequence_checker failed");
      $finish;
   end

endmodule
